// ----- rtl/csvfl_pkg.sv -----
`default_nettype none

package csvfl_pkg;

  // Default sizing, handed down from the top level
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned MAX_COLUMNS_DEF = 1024;

  // Result queue sizing
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Configuration register indexes
  localparam logic [1:0] CFG_FILTER_MODE   = 2'd0;
  localparam logic [1:0] CFG_TARGET_COLUMN = 2'd1;
  localparam logic [1:0] CFG_TARGET_ROW    = 2'd2;

  // Filter modes; the fourth code reports nothing
  typedef enum logic [1:0] {
    FM_ALL    = 2'd0,
    FM_COLUMN = 2'd1,
    FM_CELL   = 2'd2
  } filter_mode_e;

  typedef struct packed {
    logic [1:0]  filter_mode;
    logic [9:0]  target_column;
    logic [31:0] target_row;
  } cfg_t;

  typedef struct packed {
    logic [31:0] field_offset;
    logic [31:0] field_length;
    logic [9:0]  column_index;
    logic [31:0] row_index;
    logic        is_header;
    logic        row_end;
    logic        column_saturated;
    logic        final_result;
  } result_t;

  // Up to two results per byte, packed into the low slots
  typedef struct packed {
    logic [1:0] count;
    result_t    slot_a;
    result_t    slot_b;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/csvfl_scan.sv -----
`default_nettype none

module csvfl_scan #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [7:0]       byte_value_i,
  input  wire logic             last_byte_i,
  input  wire csvfl_pkg::cfg_t  cfg_i,
  output csvfl_pkg::push_t      push_o
);
  import csvfl_pkg::*;

  localparam int unsigned COL_BITS = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned CMP_BITS = (COL_BITS > 10) ? COL_BITS : 10;
  localparam logic [COL_BITS-1:0]    COL_MAX = COL_BITS'(MAX_COLUMNS - 1);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  // Scanner state
  logic                   in_quotes_q, in_quotes_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [COL_BITS-1:0]    col_q, col_d;
  logic [31:0]            line_q, line_d;
  logic                   prev_cr_q, prev_cr_d;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic passes(input logic [31:0] line, input logic [COL_BITS-1:0] col);
    logic col_hit;
    col_hit = (CMP_BITS'(col) == CMP_BITS'(cfg_i.target_column));
    case (cfg_i.filter_mode)
      FM_ALL:    return 1'b1;
      FM_COLUMN: return col_hit;
      FM_CELL:   return (line != 32'd0) && ((line - 32'd1) == cfg_i.target_row) && col_hit;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic result_t emit(input logic [OFFSET_BITS-1:0] fbeg,
                                   input logic [OFFSET_BITS-1:0] fend,
                                   input logic                   trim,
                                   input logic [31:0]            line,
                                   input logic [COL_BITS-1:0]    col,
                                   input logic                   rend);
    result_t r;
    logic [OFFSET_BITS-1:0] len;
    len = (fend > fbeg) ? fend - fbeg : '0;
    if (trim && (len != '0)) len = len - 1'b1;
    r.field_offset     = 32'(fbeg);
    r.field_length     = 32'(len);
    r.column_index     = 10'(col);
    r.row_index        = (line == 32'd0) ? 32'd0 : line - 32'd1;
    r.is_header        = (line == 32'd0);
    r.row_end          = rend;
    r.column_saturated = (col == COL_MAX);
    r.final_result     = 1'b0;
    return r;
  endfunction

  // Byte classification
  logic is_quote, is_cr, is_sep, is_lf_sep;
  assign is_quote  = (byte_value_i == CH_QUOTE);
  assign is_cr     = (byte_value_i == CH_CR);
  assign is_sep    = !in_quotes_q && ((byte_value_i == CH_COMMA) || (byte_value_i == CH_LF));
  assign is_lf_sep = is_sep && (byte_value_i == CH_LF);

  // Field bounds and counters after this byte
  logic [OFFSET_BITS-1:0] pos_inc, begin_after;
  logic [COL_BITS-1:0]    col_after;
  logic [31:0]            line_after;
  assign pos_inc     = sat_inc(offset_q);
  assign begin_after = is_sep ? pos_inc : begin_q;

  always_comb begin
    col_after = col_q;
    if (is_lf_sep) begin
      col_after = '0;
    end else if (is_sep && (col_q != COL_MAX)) begin
      col_after = col_q + 1'b1;
    end
  end

  assign line_after = (is_lf_sep && (line_q != 32'hFFFF_FFFF)) ? line_q + 32'd1 : line_q;

  // Separator field and final field
  result_t res_sep, res_fin;
  logic    v_sep, v_fin;

  always_comb begin
    res_sep = emit(begin_q, offset_q, prev_cr_q, line_q, col_q, is_lf_sep);
    res_fin = emit(begin_after, pos_inc, is_cr, line_q, col_after, 1'b1);
    v_sep   = fire_i && is_sep && passes(line_q, col_q);
    v_fin   = fire_i && last_byte_i && !is_lf_sep && passes(line_q, col_after);
    res_fin.final_result = 1'b1;
    res_sep.final_result = last_byte_i && !v_fin;
  end

  // Pack the surviving results into the low slots
  always_comb begin
    push_o.count  = {1'b0, v_sep} + {1'b0, v_fin};
    push_o.slot_a = v_sep ? res_sep : res_fin;
    push_o.slot_b = res_fin;
  end

  // Next state; the last byte returns everything to reset
  always_comb begin
    in_quotes_d = in_quotes_q;
    offset_d    = offset_q;
    begin_d     = begin_q;
    col_d       = col_q;
    line_d      = line_q;
    prev_cr_d   = prev_cr_q;
    if (fire_i) begin
      if (last_byte_i) begin
        in_quotes_d = 1'b0;
        offset_d    = '0;
        begin_d     = '0;
        col_d       = '0;
        line_d      = '0;
        prev_cr_d   = 1'b0;
      end else begin
        in_quotes_d = in_quotes_q ^ is_quote;
        offset_d    = pos_inc;
        begin_d     = begin_after;
        col_d       = col_after;
        line_d      = line_after;
        prev_cr_d   = is_cr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q <= 1'b0;
      offset_q    <= '0;
      begin_q     <= '0;
      col_q       <= '0;
      line_q      <= '0;
      prev_cr_q   <= 1'b0;
    end else begin
      in_quotes_q <= in_quotes_d;
      offset_q    <= offset_d;
      begin_q     <= begin_d;
      col_q       <= col_d;
      line_q      <= line_d;
      prev_cr_q   <= prev_cr_d;
    end
  end

`ifndef SYNTHESIS
  // End of text leaves the scanner in its reset state
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_byte_i |=> (offset_q == '0) && (begin_q == '0) && (col_q == '0)
      && (line_q == 32'd0) && !in_quotes_q && !prev_cr_q)
    else $error("scanner state not cleared after last byte");

  // A field never starts past the current offset
  a_begin_le_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    begin_q <= offset_q)
    else $error("field begin ahead of byte offset");

  // Two results only on the last byte, and only the second is marked final
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> last_byte_i && push_o.slot_b.final_result
      && !push_o.slot_a.final_result)
    else $error("bad final marking on a double result");
`endif

endmodule

`default_nettype wire

// ----- rtl/csvfl_queue.sv -----
`default_nettype none

module csvfl_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire csvfl_pkg::push_t    push_i,
  output logic                     room_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output csvfl_pkg::result_t       out_data_o
);
  import csvfl_pkg::*;

  result_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 pop;

  // Room for a full two-result beat
  assign room_o      = (cnt_q <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q + QPTR_BITS'(push_i.count);
    rd_d  = rd_q + QPTR_BITS'(pop);
    cnt_d = cnt_q + QCNT_BITS'(push_i.count) - QCNT_BITS'(pop);
  end

  // Result storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.slot_a;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + QPTR_BITS'(1)] <= push_i.slot_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  // Occupancy stays within the storage
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // Pointers and count stay consistent
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPTR_BITS'(wr_q - rd_q) == QPTR_BITS'(cnt_q))
    else $error("result queue pointers disagree with count");

  // A waiting result beat is not withdrawn
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped before the beat was taken");
`endif

endmodule

`default_nettype wire

// ----- rtl/csv_field_locator.sv -----
// Quote-aware CSV field locator. Takes one byte of text per cycle while in_ready_o is high and
// reports, for every field that a comma or LF outside quotes closes and that passes the filter,
// its start offset, its length (one trailing CR trimmed), column, data row and flags; the last
// byte also reports a pending final field. A byte is taken in the cycle it is offered while
// in_ready_o is high, and its results are registered in a four-entry queue that the output
// drains at one beat per cycle while out_ready_i is high: in_ready_o drops while fewer than two
// entries are free, which happens only when the output side stalls or the final byte yields two
// results. Configuration writes are always accepted and should be made between texts.
`default_nettype none

module csv_field_locator #(
  parameter int unsigned OFFSET_BITS = csvfl_pkg::OFFSET_BITS_DEF,
  parameter int unsigned MAX_COLUMNS = csvfl_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        last_byte_i,
  // Field results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      field_offset_o,
  output logic [31:0]      field_length_o,
  output logic [9:0]       column_index_o,
  output logic [31:0]      row_index_o,
  output logic             is_header_o,
  output logic             row_end_o,
  output logic             column_saturated_o,
  output logic             final_result_o,
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import csvfl_pkg::*;

  cfg_t    cfg_q;
  push_t   push;
  result_t res;
  logic    room, fire;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FILTER_MODE:   cfg_q.filter_mode   <= cfg_data_i[1:0];
        CFG_TARGET_COLUMN: cfg_q.target_column <= cfg_data_i[9:0];
        CFG_TARGET_ROW:    cfg_q.target_row    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input beat handshake
  assign in_ready_o = room;
  assign fire       = in_valid_i && room;

  csvfl_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .cfg_i        (cfg_q),
    .push_o       (push)
  );

  csvfl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res)
  );

  // Result fields
  assign field_offset_o     = res.field_offset;
  assign field_length_o     = res.field_length;
  assign column_index_o     = res.column_index;
  assign row_index_o        = res.row_index;
  assign is_header_o        = res.is_header;
  assign row_end_o          = res.row_end;
  assign column_saturated_o = res.column_saturated;
  assign final_result_o     = res.final_result;

endmodule

`default_nettype wire

// ----- verif/csv_field_locator_tb.sv -----
`timescale 1ns / 1ps

module csv_field_locator_tb;
  import csvfl_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WIDE_COMMAS    = 1030;

  localparam logic [9:0] COL_MAX   = 10'(MAX_COLUMNS_DEF - 1);
  // Fourth filter code, no matching fields
  localparam logic [1:0] FM_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] value;
    bit         is_last;
  } text_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic [7:0]  byte_value;
  logic        last_byte;
  logic        out_ready;
  logic        cfg_valid;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  logic        in_ready;
  logic        out_valid;
  logic [31:0] field_offset;
  logic [31:0] field_length;
  logic [9:0]  column_index;
  logic [31:0] row_index;
  logic        is_header;
  logic        row_end;
  logic        column_saturated;
  logic        final_result;
  logic        cfg_ready;

  // Handshake flags sampled at the rising edge, read by the falling-edge processes
  bit in_beat  = 1'b0;
  bit out_beat = 1'b0;
  bit cfg_beat = 1'b0;

  // Stimulus bookkeeping
  text_byte_t byte_q[$];
  text_byte_t tx_byte;
  int         bytes_queued = 0;
  int         bytes_taken  = 0;
  int         texts_queued = 0;
  int         tx_wait      = 0;
  int         rx_wait      = 0;
  int         hold_asked   = 0;
  int         hold_served  = 0;
  int         hold_left    = 0;
  bit         no_idle      = 1'b0;
  int         idle_cycles  = 0;

  int         fields_checked = 0;
  int         mismatches     = 0;

  // Field tracking state and register copies used for prediction
  bit          tk_in_quotes;
  logic [31:0] tk_offset;
  logic [31:0] tk_field_start;
  logic [9:0]  tk_column;
  logic [31:0] tk_line;
  bit          tk_prev_cr;
  logic [1:0]  cfg_mode   = FM_ALL;
  logic [9:0]  cfg_column = '0;
  logic [31:0] cfg_row    = '0;
  result_t     pending_fields[$];

  csv_field_locator DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .byte_value_i       (byte_value),
    .last_byte_i        (last_byte),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .field_offset_o     (field_offset),
    .field_length_o     (field_length),
    .column_index_o     (column_index),
    .row_index_o        (row_index),
    .is_header_o        (is_header),
    .row_end_o          (row_end),
    .column_saturated_o (column_saturated),
    .final_result_o     (final_result),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Field locator prediction
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] sat_next(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void clear_tracking();
    tk_in_quotes   = 1'b0;
    tk_offset      = '0;
    tk_field_start = '0;
    tk_column      = '0;
    tk_line        = '0;
    tk_prev_cr     = 1'b0;
  endfunction

  function automatic bit field_selected(logic [31:0] row, bit header);
    case (cfg_mode)
      FM_ALL:    return 1'b1;
      FM_COLUMN: return tk_column == cfg_column;
      FM_CELL:   return !header && row == cfg_row && tk_column == cfg_column;
      default:   return 1'b0;
    endcase
  endfunction

  // Close the open field at 'stop' (one past its last byte); returns 1 if reported
  function automatic bit close_field(logic [31:0] stop, bit trim_cr, bit ends_row);
    logic [31:0] len;
    logic [31:0] row;
    bit          header;
    result_t     r;
    len    = (stop > tk_field_start) ? stop - tk_field_start : 32'd0;
    header = (tk_line == 0);
    row    = header ? 32'd0 : tk_line - 32'd1;
    if (trim_cr && len != 0) len--;
    if (!field_selected(row, header)) return 1'b0;
    r.field_offset     = tk_field_start;
    r.field_length     = len;
    r.column_index     = tk_column;
    r.row_index        = row;
    r.is_header        = header;
    r.row_end          = ends_row;
    r.column_saturated = (tk_column == COL_MAX);
    r.final_result     = 1'b0;
    pending_fields = {pending_fields, r};
    return 1'b1;
  endfunction

  function automatic void track_byte(logic [7:0] ch, bit is_last);
    logic [31:0] pos;
    bit          lf_end;
    bit          reported;
    result_t     r;
    pos      = tk_offset;
    lf_end   = 1'b0;
    reported = 1'b0;
    if (ch == CH_QUOTE) begin
      tk_in_quotes = !tk_in_quotes;
    end else if ((ch == CH_COMMA || ch == CH_LF) && !tk_in_quotes) begin
      reported       = close_field(pos, tk_prev_cr, ch == CH_LF);
      tk_field_start = sat_next(pos);
      if (ch == CH_LF) begin
        tk_column = '0;
        if (tk_line != '1) tk_line++;
        lf_end = 1'b1;
      end else if (tk_column != COL_MAX) begin
        tk_column++;
      end
    end
    tk_prev_cr = (ch == CH_CR);
    tk_offset  = sat_next(pos);
    if (is_last) begin
      // Pending field closes on the last byte unless an LF just did it
      if (!lf_end) begin
        if (close_field(sat_next(pos), ch == CH_CR, 1'b1)) reported = 1'b1;
      end
      if (reported) begin
        r = pending_fields.pop_back();
        r.final_result = 1'b1;
        pending_fields = {pending_fields, r};
      end
      clear_tracking();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input beats, checks output beats
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_beat  <= in_valid && in_ready;
    out_beat <= out_valid && out_ready;
    cfg_beat <= cfg_valid && cfg_ready;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FILTER_MODE:   cfg_mode   = cfg_data[1:0];
          CFG_TARGET_COLUMN: cfg_column = cfg_data[9:0];
          CFG_TARGET_ROW:    cfg_row    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        track_byte(byte_value, last_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (pending_fields.size() == 0) begin
          $error("unexpected field result: offset %0d length %0d", field_offset, field_length);
          mismatches++;
        end else begin
          result_t want;
          want = pending_fields.pop_front();
          check_field("field_offset", want.field_offset, field_offset);
          check_field("field_length", want.field_length, field_length);
          check_field("column_index", 32'(want.column_index), 32'(column_index));
          check_field("row_index", want.row_index, row_index);
          check_field("is_header", 32'(want.is_header), 32'(is_header));
          check_field("row_end", 32'(want.row_end), 32'(row_end));
          check_field("column_saturated", 32'(want.column_saturated),
                      32'(column_saturated));
          check_field("final_result", 32'(want.final_result), 32'(final_result));
          fields_checked++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d fields outstanding", pending_fields.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver: pops the next byte once the current one is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (in_beat || !in_valid)) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        tx_byte = byte_q.pop_front();
        byte_value <= tx_byte.value;
        last_byte  <= tx_byte.is_last;
        in_valid   <= 1'b1;
        tx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls per beat, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (out_beat) rx_wait = no_idle ? 0 : $urandom_range(0, 3);
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_COMMA || c == CH_LF || c == CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_LF;
      3: return CH_CR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_field(ref logic [7:0] txt[$]);
    int         kind;
    int         n;
    logic [7:0] c;
    kind = $urandom_range(0, 5);
    n    = $urandom_range(0, 6);
    if (kind == 0) return;
    if (kind >= 4) begin
      // quoted field; separators and CR/LF inside, quotes doubled
      txt = {txt, CH_QUOTE};
      repeat (n) begin
        c = noise_char();
        txt = {txt, c};
        if (c == CH_QUOTE) txt = {txt, CH_QUOTE};
      end
      txt = {txt, CH_QUOTE};
    end else begin
      repeat (n) txt = {txt, plain_char()};
      if ($urandom_range(0, 7) == 0) txt = {txt, CH_CR};
    end
  endfunction

  function automatic void build_table(ref logic [7:0] txt[$]);
    int rows;
    int cols;
    int tail;
    rows = $urandom_range(1, 5);
    for (int r = 0; r < rows; r++) begin
      cols = $urandom_range(1, 5);
      for (int k = 0; k < cols; k++) begin
        if (k != 0) txt = {txt, CH_COMMA};
        add_field(txt);
      end
      // line ends: CRLF, LF, none on the last line, or a dangling comma
      tail = (r == rows - 1) ? $urandom_range(0, 3) : $urandom_range(0, 1);
      if (tail == 1) txt = {txt, CH_CR};
      if (tail <= 1) txt = {txt, CH_LF};
      else if (tail == 3) txt = {txt, CH_COMMA};
    end
  endfunction

  function automatic void queue_text(logic [7:0] txt[$]);
    text_byte_t b;
    foreach (txt[i]) begin
      b.value   = txt[i];
      b.is_last = (i == txt.size() - 1);
      byte_q = {byte_q, b};
    end
    bytes_queued += txt.size();
    texts_queued++;
  endfunction

  // Wait until every byte is taken and every field has come back
  task automatic drain();
    while (bytes_taken != bytes_queued || pending_fields.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(negedge clk_i); while (!cfg_beat);
  endtask

  task automatic write_config(logic [1:0] mode, logic [9:0] column, logic [31:0] row);
    write_reg(CFG_FILTER_MODE, 32'(mode));
    write_reg(CFG_TARGET_COLUMN, 32'(column));
    write_reg(CFG_TARGET_ROW, row);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly well-formed tables; some with a stray quote, some raw noise
  task automatic run_texts(int budget, bit with_hold);
    logic [7:0] txt[$];
    int         start;
    int         pick;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      txt.delete();
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        repeat ($urandom_range(1, 30)) txt = {txt, noise_char()};
      end else begin
        build_table(txt);
        if (txt.size() == 0) txt = {txt, plain_char()};
        if (pick < 6) txt.insert($urandom_range(0, txt.size() - 1), CH_QUOTE);
      end
      queue_text(txt);
    end
    if (with_hold) hold_asked++;
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] txt[$];
    clear_tracking();
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    byte_value = '0;
    last_byte  = 1'b0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_FILTER_MODE;
    cfg_data   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_config(FM_ALL, '0, '0);

    // Quoted comma and LF, CRLF trim, empty field, final field ending in CR
    txt = {8'h61, 8'h62, CH_COMMA, CH_QUOTE, 8'h63, CH_COMMA, CH_LF, CH_QUOTE,
           CH_CR, CH_LF, CH_COMMA, 8'h78, CH_CR};
    queue_text(txt);
    // Byte extremes, text closed by an LF on the last byte
    txt = {8'hFF, 8'h00, CH_COMMA, CH_LF};
    queue_text(txt);
    // Text ending inside quotes
    txt = {CH_QUOTE, 8'h61};
    queue_text(txt);
    // Lone comma: two empty fields; lone LF: one
    txt = {CH_COMMA};
    queue_text(txt);
    txt = {CH_LF};
    queue_text(txt);
    drain();

    // Back-to-back beats with no stalls on either side
    no_idle = 1'b1;
    run_texts(60, 1'b0);
    no_idle = 1'b0;
    run_texts(60, 1'b1);

    write_config(FM_COLUMN, '0, '0);
    run_texts(50, 1'b1);
    write_config(FM_COLUMN, 10'd2, '0);
    run_texts(40, 1'b0);

    write_config(FM_CELL, '0, '0);
    run_texts(40, 1'b0);
    write_config(FM_CELL, 10'd1, 32'd1);
    run_texts(40, 1'b0);
    write_config(FM_CELL, COL_MAX, '1);
    run_texts(30, 1'b0);

    write_config(FM_UNUSED, 10'd1, '0);
    run_texts(30, 1'b0);

    // One row wide enough to saturate the column counter
    write_config(FM_COLUMN, COL_MAX, '0);
    txt.delete();
    repeat (WIDE_COMMAS) txt = {txt, CH_COMMA};
    txt = {txt, CH_LF};
    queue_text(txt);
    drain();

    write_config(FM_ALL, '0, '0);
    run_texts(50, 1'b1);

    $display("Checked %0d fields from %0d bytes in %0d texts", fields_checked, bytes_taken,
             texts_queued);
    $display("Covered all filter modes, quoting, CR trimming, column saturation and stalls");
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
